// ----- design/hmc_pkg.sv -----
// Shared widths, codes and reset values for the heater mode controller.
package hmc_pkg;

    localparam int EVENT_W  = 3;
    localparam int TEMP_W   = 14;
    localparam int STEP_W   = 10;
    localparam int CALIB_W  = 16;
    localparam int CURSOR_W = 2;
    localparam int FAULT_W  = 2;
    localparam int MODE_W   = 3;
    localparam int SOFF_W   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE    = 3'd0,
        MODE_WORKING = 3'd1,
        MODE_CALIB   = 3'd2,
        MODE_MENU    = 3'd3,
        MODE_ERROR   = 3'd4
    } mode_t;

    typedef enum logic [FAULT_W-1:0] {
        FAULT_NONE     = 2'd0,
        FAULT_WATCHDOG = 2'd1,
        FAULT_SENSOR   = 2'd2,
        FAULT_OVERTEMP = 2'd3
    } fault_t;

    localparam logic [EVENT_W-1:0] EV_NONE   = 3'd0;
    localparam logic [EVENT_W-1:0] EV_CLICK  = 3'd1;
    localparam logic [EVENT_W-1:0] EV_DOUBLE = 3'd2;
    localparam logic [EVENT_W-1:0] EV_LONG   = 3'd3;
    localparam logic [EVENT_W-1:0] EV_CW     = 3'd4;
    localparam logic [EVENT_W-1:0] EV_CCW    = 3'd5;

    localparam logic [CURSOR_W-1:0] ITEM_PID       = 2'd0;
    localparam logic [CURSOR_W-1:0] ITEM_CALIBRATE = 2'd1;
    localparam logic [CURSOR_W-1:0] ITEM_INFO      = 2'd2;
    localparam logic [CURSOR_W-1:0] ITEM_DEFAULTS  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_OVERTEMP_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_MIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_MAX     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_TARGET   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET   = 3'd4;

    localparam logic signed [TEMP_W-1:0]  RST_OVERTEMP   = 14'sd4500;
    localparam logic signed [TEMP_W-1:0]  RST_TARGET_MIN = 14'sd1000;
    localparam logic signed [TEMP_W-1:0]  RST_TARGET_MAX = 14'sd4000;
    localparam logic signed [TEMP_W-1:0]  RST_TARGET     = 14'sd3000;
    localparam logic signed [CALIB_W-1:0] RST_OFFSET     = 16'sd0;

    localparam logic signed [CALIB_W-1:0] OFFSET_MAX = 16'sh7FFF;
    localparam logic signed [CALIB_W-1:0] OFFSET_MIN = 16'sh8000;

endpackage

// ----- design/heater_mode_controller.sv -----
// Heater mode controller: fault checks, mode sequencing, target and calibration handling.
// An item passes two registers, input and result, with the combinational state update between.
// Throughput: one item per cycle unless out_stall holds a full result register.
// in_stall rises only while the result register is full and out_stall holds it.
// Reset: asynchronous, active low; idle mode, no fault, heater off, cursor 0, target 3000,
// offsets 0 and the configuration registers at their documented defaults.
module heater_mode_controller (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic        [hmc_pkg::EVENT_W-1:0]   event_req,
    input  logic signed [hmc_pkg::TEMP_W-1:0]    temperature,
    input  logic                                 sensor_ok,
    input  logic                                 watchdog_fired,
    input  logic        [hmc_pkg::STEP_W-1:0]    encoder_step,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic        [hmc_pkg::MODE_W-1:0]    mode,
    output logic        [hmc_pkg::FAULT_W-1:0]   error_code,
    output logic                                 heater_enable,
    output logic                                 emergency_stop,
    output logic                                 pid_run,
    output logic signed [hmc_pkg::TEMP_W-1:0]    target_temp,
    output logic signed [hmc_pkg::CALIB_W-1:0]   calib_offset,
    output logic signed [hmc_pkg::CALIB_W-1:0]   applied_calib,
    output logic        [hmc_pkg::CURSOR_W-1:0]  menu_item,
    output logic                                 save_request,
    output logic                                 reset_tunings,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic        [hmc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [hmc_pkg::CFG_DATA_W-1:0] cfg_data
);

    import hmc_pkg::*;

    // configuration
    logic signed [TEMP_W-1:0] overtemp_reg;
    logic signed [TEMP_W-1:0] tmin_reg;
    logic signed [TEMP_W-1:0] tmax_reg;

    // controller state
    mode_t                      mode_reg,    mode_next;
    mode_t                      prior_reg,   prior_next;
    fault_t                     fault_reg,   fault_next;
    logic signed [TEMP_W-1:0]   target_reg,  target_next;
    logic signed [CALIB_W-1:0]  offset_reg,  offset_next;
    logic signed [CALIB_W-1:0]  applied_reg, applied_next;
    logic [CURSOR_W-1:0]        cursor_reg,  cursor_next;
    logic                       heat_reg,    heat_next;

    // input register
    logic                       s1_valid_reg;
    logic [EVENT_W-1:0]         s1_event_reg;
    logic signed [TEMP_W-1:0]   s1_temp_reg;
    logic                       s1_sensor_ok_reg;
    logic                       s1_wdog_reg;
    logic [STEP_W-1:0]          s1_step_reg;

    // result register
    logic                       out_valid_reg;
    mode_t                      out_mode_reg;
    fault_t                     out_fault_reg;
    logic                       out_heat_reg;
    logic                       out_estop_reg;
    logic                       out_pid_reg;
    logic signed [TEMP_W-1:0]   out_target_reg;
    logic signed [CALIB_W-1:0]  out_offset_reg;
    logic signed [CALIB_W-1:0]  out_applied_reg;
    logic [CURSOR_W-1:0]        out_cursor_reg;
    logic                       out_save_reg;
    logic                       out_rtun_reg;

    logic                       advance;
    logic                       in_load;
    logic                       estop_next;
    logic                       pid_next;
    logic                       save_next;
    logic                       rtun_next;
    fault_t                     fault_found;
    logic                       go;
    mode_t                      go_mode;
    logic signed [CALIB_W-1:0]  move_sum;
    logic signed [CALIB_W-1:0]  move_hi;
    logic signed [CALIB_W-1:0]  move_clamped;
    logic signed [CALIB_W-1:0]  step_ext;
    logic signed [CALIB_W-1:0]  tmin_ext;
    logic signed [CALIB_W-1:0]  tmax_ext;

    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_load   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // fault priority: watchdog, sensor, overtemperature
    always_comb
    begin
        if (s1_wdog_reg)
            fault_found = FAULT_WATCHDOG;
        else if (!s1_sensor_ok_reg)
            fault_found = FAULT_SENSOR;
        else if (s1_temp_reg > overtemp_reg)
            fault_found = FAULT_OVERTEMP;
        else
            fault_found = FAULT_NONE;
    end

    // target move with saturation: upper bound first, then lower
    assign step_ext = signed'({{(CALIB_W-STEP_W){1'b0}}, s1_step_reg});
    assign tmin_ext = CALIB_W'(tmin_reg);
    assign tmax_ext = CALIB_W'(tmax_reg);

    always_comb
    begin
        if (s1_event_reg == EV_CCW)
            move_sum = CALIB_W'(target_reg) - step_ext;
        else
            move_sum = CALIB_W'(target_reg) + step_ext;
        move_hi      = (move_sum > tmax_ext) ? tmax_ext : move_sum;
        move_clamped = (move_hi < tmin_ext) ? tmin_ext : move_hi;
    end

    // next state
    always_comb
    begin
        mode_next    = mode_reg;
        prior_next   = prior_reg;
        fault_next   = fault_reg;
        target_next  = target_reg;
        offset_next  = offset_reg;
        applied_next = applied_reg;
        cursor_next  = cursor_reg;
        heat_next    = heat_reg;
        estop_next   = 1'b0;
        pid_next     = 1'b0;
        save_next    = 1'b0;
        rtun_next    = 1'b0;
        go           = 1'b0;
        go_mode      = mode_reg;

        if (fault_found != FAULT_NONE)
        begin
            fault_next = fault_found;
            heat_next  = 1'b0;
            estop_next = 1'b1;
            go         = 1'b1;
            go_mode    = MODE_ERROR;
        end
        else
        begin
            unique case (mode_reg)
                MODE_IDLE:
                begin
                    case (s1_event_reg)
                        EV_CLICK:
                        begin
                            go      = 1'b1;
                            go_mode = MODE_WORKING;
                        end
                        EV_LONG:
                        begin
                            go      = 1'b1;
                            go_mode = MODE_MENU;
                        end
                        EV_CW, EV_CCW: target_next = move_clamped[TEMP_W-1:0];
                        default: ;
                    endcase
                end
                MODE_WORKING:
                begin
                    pid_next = 1'b1;
                    case (s1_event_reg)
                        EV_DOUBLE:
                        begin
                            heat_next = 1'b0;
                            go        = 1'b1;
                            go_mode   = MODE_IDLE;
                        end
                        EV_LONG:
                        begin
                            heat_next = 1'b0;
                            go        = 1'b1;
                            go_mode   = MODE_MENU;
                        end
                        EV_CW, EV_CCW: target_next = move_clamped[TEMP_W-1:0];
                        default: ;
                    endcase
                end
                MODE_CALIB:
                begin
                    case (s1_event_reg)
                        EV_DOUBLE:
                        begin
                            go      = 1'b1;
                            go_mode = prior_reg;
                        end
                        EV_LONG:
                        begin
                            applied_next = offset_reg;
                            save_next    = 1'b1;
                            go           = 1'b1;
                            go_mode      = prior_reg;
                        end
                        EV_CW:
                        begin
                            if (offset_reg != OFFSET_MAX)
                                offset_next = offset_reg + 16'sd1;
                        end
                        EV_CCW:
                        begin
                            if (offset_reg != OFFSET_MIN)
                                offset_next = offset_reg - 16'sd1;
                        end
                        default: ;
                    endcase
                end
                MODE_MENU:
                begin
                    case (s1_event_reg)
                        EV_CLICK:
                        begin
                            if (cursor_reg == ITEM_CALIBRATE)
                            begin
                                go      = 1'b1;
                                go_mode = MODE_CALIB;
                            end
                            else if (cursor_reg == ITEM_DEFAULTS)
                            begin
                                rtun_next    = 1'b1;
                                save_next    = 1'b1;
                                applied_next = '0;
                            end
                        end
                        EV_DOUBLE:
                        begin
                            go      = 1'b1;
                            go_mode = MODE_IDLE;
                        end
                        EV_CW:  cursor_next = cursor_reg + 2'd1;
                        EV_CCW: cursor_next = cursor_reg - 2'd1;
                        default: ;
                    endcase
                end
                MODE_ERROR:
                begin
                    heat_next  = 1'b0;
                    estop_next = 1'b1;
                    if (s1_event_reg == EV_LONG)
                    begin
                        fault_next = FAULT_NONE;
                        go         = 1'b1;
                        go_mode    = MODE_IDLE;
                    end
                end
                default: ;
            endcase
        end

        // mode change: keep the old mode, drive the heater on entry
        if (go && (go_mode != mode_reg))
        begin
            prior_next = mode_reg;
            mode_next  = go_mode;
            if (go_mode == MODE_IDLE)
                heat_next = 1'b0;
            else if (go_mode == MODE_WORKING)
                heat_next = 1'b1;
        end
    end

    // handshake control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_load)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overtemp_reg <= RST_OVERTEMP;
            tmin_reg     <= RST_TARGET_MIN;
            tmax_reg     <= RST_TARGET_MAX;
            mode_reg     <= MODE_IDLE;
            prior_reg    <= MODE_IDLE;
            fault_reg    <= FAULT_NONE;
            target_reg   <= RST_TARGET;
            offset_reg   <= RST_OFFSET;
            applied_reg  <= RST_OFFSET;
            cursor_reg   <= ITEM_PID;
            heat_reg     <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                mode_reg    <= mode_next;
                prior_reg   <= prior_next;
                fault_reg   <= fault_next;
                target_reg  <= target_next;
                offset_reg  <= offset_next;
                applied_reg <= applied_next;
                cursor_reg  <= cursor_next;
                heat_reg    <= heat_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_OVERTEMP_LIMIT: overtemp_reg <= signed'(cfg_data);
                    CFG_TARGET_MIN:     tmin_reg     <= signed'(cfg_data);
                    CFG_TARGET_MAX:     tmax_reg     <= signed'(cfg_data);
                    CFG_START_TARGET:   target_reg   <= signed'(cfg_data);
                    CFG_START_OFFSET:
                    begin
                        offset_reg  <= CALIB_W'(signed'(cfg_data[SOFF_W-1:0]));
                        applied_reg <= CALIB_W'(signed'(cfg_data[SOFF_W-1:0]));
                    end
                    default: ;
                endcase
            end
        end
    end

    // input and result payload
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            s1_event_reg     <= event_req;
            s1_temp_reg      <= temperature;
            s1_sensor_ok_reg <= sensor_ok;
            s1_wdog_reg      <= watchdog_fired;
            s1_step_reg      <= encoder_step;
        end
        if (advance)
        begin
            out_mode_reg    <= mode_next;
            out_fault_reg   <= fault_next;
            out_heat_reg    <= heat_next;
            out_estop_reg   <= estop_next;
            out_pid_reg     <= pid_next;
            out_target_reg  <= target_next;
            out_offset_reg  <= offset_next;
            out_applied_reg <= applied_next;
            out_cursor_reg  <= cursor_next;
            out_save_reg    <= save_next;
            out_rtun_reg    <= rtun_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign mode           = out_mode_reg;
    assign error_code     = out_fault_reg;
    assign heater_enable  = out_heat_reg;
    assign emergency_stop = out_estop_reg;
    assign pid_run        = out_pid_reg;
    assign target_temp    = out_target_reg;
    assign calib_offset   = out_offset_reg;
    assign applied_calib  = out_applied_reg;
    assign menu_item      = out_cursor_reg;
    assign save_request   = out_save_reg;
    assign reset_tunings  = out_rtun_reg;

    a_heat_only_working: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && heater_enable) |-> (mode == MODE_WORKING))
        else $error("heater enabled outside working mode");

    a_fault_means_error: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (error_code != FAULT_NONE)) |-> (mode == MODE_ERROR))
        else $error("fault code held outside error mode");

    a_save_source: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && save_request) |->
            ((applied_calib == calib_offset) || (reset_tunings && (applied_calib == '0))))
        else $error("save pulse without a matching applied calibration");

endmodule
